>>> rtl/assert_macros.svh
// assertion macros used by the checker file tcpq_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tcpq_pkg.sv
// shared types and constants for the three-class priority call queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

    // total number of calls held across all classes
    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // word widths on the stream ports
    localparam int IN_W  = 88;
    localparam int OUT_W = 96;

    // dismiss count field
    localparam int DROP_W   = 7;
    localparam int DROP_MAX = 127;
    localparam int SAT_W    = (CNT_W > DROP_W) ? CNT_W : DROP_W;

    typedef enum logic [2:0] {
        OP_ENQ_DATA  = 3'd0,
        OP_ENQ_VOICE = 3'd1,
        OP_ENQ_EMERG = 3'd2,
        OP_SERVE     = 3'd3,
        OP_DISMISS   = 3'd4
    } opcode_t;

    localparam logic [2:0] ST_ENQUEUED  = 3'd0;
    localparam logic [2:0] ST_SERVED    = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DISMISSED = 3'd4;

    // higher code means higher priority
    localparam logic [1:0] CLS_DATA  = 2'd0;
    localparam logic [1:0] CLS_VOICE = 2'd1;
    localparam logic [1:0] CLS_EMERG = 2'd2;

    typedef struct packed {
        logic [31:0] caller;
        logic [31:0] callee;
        logic [15:0] packets;
        logic        show_id;
        logic        roaming;
    } call_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
        call_t      call;
    } slot_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SERVE,
        CMD_DROP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t  cmd;
        logic [1:0] new_cls;
        logic [1:0] drop_cls;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tcpq_cell.sv
// one cell of the sorted call chain: holds one call and its class
// depends on tcpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpq_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tcpq_pkg::cell_ctrl_t ctrl_i,
    input  wire tcpq_pkg::call_t     new_call_i,
    input  wire logic                left_goes_i,
    input  wire tcpq_pkg::slot_t     left_i,
    input  wire tcpq_pkg::slot_t     right_i,
    output logic                     goes_o,
    output tcpq_pkg::slot_t          slot_o
);
    import tcpq_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] cls_reg, cls_next;
    call_t      call_reg, call_next;

    // this cell sits at or behind the insertion point
    assign goes_o = !valid_reg || (cls_reg < ctrl_i.new_cls);

    always_comb begin
        valid_next = valid_reg;
        cls_next   = cls_reg;
        call_next  = call_reg;
        case (ctrl_i.cmd)
            CMD_INSERT: begin
                if (goes_o && left_goes_i) begin
                    valid_next = left_i.valid;
                    cls_next   = left_i.cls;
                    call_next  = left_i.call;
                end else if (goes_o) begin
                    valid_next = 1'b1;
                    cls_next   = ctrl_i.new_cls;
                    call_next  = new_call_i;
                end
            end
            CMD_SERVE: begin
                valid_next = right_i.valid;
                cls_next   = right_i.cls;
                call_next  = right_i.call;
            end
            CMD_DROP: begin
                if (cls_reg == ctrl_i.drop_cls) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg  <= cls_next;
        call_reg <= call_next;
    end

    assign slot_o = '{valid: valid_reg, cls: cls_reg, call: call_reg};

endmodule

`default_nettype wire

>>> rtl/three_class_priority_call_queue.sv
// Three-class strict priority call queue (emergency, voice, data; first-in first-out
// within a class). One word is taken per clock cycle whenever the result register is
// free or being emptied in that cycle; its result is registered for the next cycle. Calls sit in
// a chain of DEPTH cells kept sorted by class, oldest first within a class, so the head
// cell always holds the next call to serve. Every cell updates in parallel from its own
// contents and its neighbors: an enqueue opens a gap at the insertion point and shifts
// the tail one cell right, a serve shifts the whole chain one cell left, a dismiss clears
// every cell of the dropped class. Per-class fill counters give the full test and the
// dismiss count. Depends on tcpq_pkg and tcpq_cell.
`timescale 1ns / 1ps
`default_nettype none

module three_class_priority_call_queue (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // opcode, caller_number, callee_number, packet_total, show_id, is_roaming, 3'b0 pad
    input  wire logic [tcpq_pkg::IN_W-1:0]  s_tdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // status, call_class, out_caller, out_callee, out_packets, out_show_id,
    // out_roaming, dropped_count, 2'b0 pad
    output logic [tcpq_pkg::OUT_W-1:0]      m_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready
);
    import tcpq_pkg::*;

    // input word fields
    logic [2:0]  in_op;
    logic [31:0] in_caller;
    logic [31:0] in_callee;
    logic [15:0] in_packets;
    logic        in_show;
    logic        in_roam;

    assign in_op      = s_tdata[2:0];
    assign in_caller  = s_tdata[34:3];
    assign in_callee  = s_tdata[66:35];
    assign in_packets = s_tdata[82:67];
    assign in_show    = s_tdata[83];
    assign in_roam    = s_tdata[84];

    // per-class fill counts
    logic [CNT_W-1:0] e_fill_reg, e_fill_next;
    logic [CNT_W-1:0] v_fill_reg, v_fill_next;
    logic [CNT_W-1:0] d_fill_reg, d_fill_next;
    logic [CNT_W+1:0] total;
    logic             full;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic             s_accept;

    // cell chain wiring
    cell_ctrl_t ctrl;
    call_t      new_call;
    slot_t      slots [DEPTH];
    logic       goes  [DEPTH];
    slot_t      head;

    // result fields
    logic [2:0]        r_status;
    logic [1:0]        r_cls;
    call_t             r_call;
    logic [DROP_W-1:0] r_dropped;
    logic [CNT_W-1:0]  drop_src;

    // the result register frees up in the same cycle it is taken
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign total = (CNT_W+2)'(e_fill_reg) + (CNT_W+2)'(v_fill_reg)
                 + (CNT_W+2)'(d_fill_reg);
    assign full  = total >= (CNT_W+2)'(DEPTH);
    assign head  = slots[0];

    // only the fields that belong to the offered class are kept
    always_comb begin
        new_call.caller  = in_caller;
        new_call.callee  = in_callee;
        new_call.packets = (in_op == OP_ENQ_DATA) ? in_packets : 16'd0;
        new_call.show_id = (in_op == OP_ENQ_VOICE) ? in_show : 1'b0;
        new_call.roaming = (in_op == OP_ENQ_VOICE) ? in_roam : 1'b0;
    end

    // operation decode and result assembly
    always_comb begin
        ctrl.cmd      = CMD_HOLD;
        ctrl.new_cls  = in_op[1:0];
        ctrl.drop_cls = CLS_DATA;
        e_fill_next   = e_fill_reg;
        v_fill_next   = v_fill_reg;
        d_fill_next   = d_fill_reg;
        r_status      = ST_FULL;
        r_cls         = CLS_DATA;
        r_call        = '0;
        r_dropped     = '0;
        drop_src      = '0;
        if (s_accept) begin
            case (opcode_t'(in_op))
                OP_ENQ_DATA, OP_ENQ_VOICE, OP_ENQ_EMERG: begin
                    r_cls = in_op[1:0];
                    if (!full) begin
                        r_status = ST_ENQUEUED;
                        ctrl.cmd = CMD_INSERT;
                        case (opcode_t'(in_op))
                            OP_ENQ_DATA:  d_fill_next = d_fill_reg + CNT_W'(1);
                            OP_ENQ_VOICE: v_fill_next = v_fill_reg + CNT_W'(1);
                            default:      e_fill_next = e_fill_reg + CNT_W'(1);
                        endcase
                    end
                end
                OP_SERVE: begin
                    if (head.valid) begin
                        r_status = ST_SERVED;
                        r_cls    = head.cls;
                        r_call   = head.call;
                        ctrl.cmd = CMD_SERVE;
                        case (head.cls)
                            CLS_EMERG: e_fill_next = e_fill_reg - CNT_W'(1);
                            CLS_VOICE: v_fill_next = v_fill_reg - CNT_W'(1);
                            default:   d_fill_next = d_fill_reg - CNT_W'(1);
                        endcase
                    end else begin
                        r_status = ST_EMPTY;
                    end
                end
                OP_DISMISS: begin
                    r_status = ST_DISMISSED;
                    // data goes first, voice only when no data call is held
                    if (d_fill_reg != '0) begin
                        ctrl.cmd      = CMD_DROP;
                        ctrl.drop_cls = CLS_DATA;
                        drop_src      = d_fill_reg;
                        d_fill_next   = '0;
                    end else if (v_fill_reg != '0) begin
                        ctrl.cmd      = CMD_DROP;
                        ctrl.drop_cls = CLS_VOICE;
                        r_cls         = CLS_VOICE;
                        drop_src      = v_fill_reg;
                        v_fill_next   = '0;
                    end
                    if (SAT_W'(drop_src) > SAT_W'(DROP_MAX)) begin
                        r_dropped = DROP_W'(DROP_MAX);
                    end else begin
                        r_dropped = DROP_W'(drop_src);
                    end
                end
                default: begin
                    // unknown opcode: refused, nothing changes
                    r_status = ST_FULL;
                end
            endcase
        end
    end

    // the chain: cell 0 is the head, new calls enter from the left at their slot
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  left_goes;
        slot_t left_slot;
        slot_t right_slot;

        if (i == 0) begin : g_first
            assign left_goes = 1'b0;
            assign left_slot = '0;
        end else begin : g_mid
            assign left_goes = goes[i-1];
            assign left_slot = slots[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slots[i+1];
        end

        tcpq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl_i      (ctrl),
            .new_call_i  (new_call),
            .left_goes_i (left_goes),
            .left_i      (left_slot),
            .right_i     (right_slot),
            .goes_o      (goes[i]),
            .slot_o      (slots[i])
        );
    end

    always_comb begin
        m_tdata_next  = {2'b00, r_dropped, r_call.roaming, r_call.show_id,
                         r_call.packets, r_call.callee, r_call.caller, r_cls, r_status};
        m_tvalid_next = s_accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_fill_reg   <= '0;
            v_fill_reg   <= '0;
            d_fill_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            e_fill_reg   <= e_fill_next;
            v_fill_reg   <= v_fill_next;
            d_fill_reg   <= d_fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result word holds while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/tcpq_checker.sv
// port-level checks for the three-class priority call queue, bound to the top level
// depends on tcpq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcpq_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [tcpq_pkg::OUT_W-1:0] m_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready
);
    import tcpq_pkg::*;

    // a stalled result word holds
    `ASSERT_CLKD(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // every accepted word yields a result in the next cycle
    `ASSERT_CLKD(a_one_result, aclk, aresetn, s_tvalid && s_tready |=> m_tvalid, "accepted word gave no result")

    // a served call never reports an unused class code
    `ASSERT_CLKD(a_served_cls, aclk, aresetn, m_tvalid && m_tdata[2:0] == ST_SERVED |-> m_tdata[4:3] != 2'd3, "served call with bad class")

    // only a dismiss reports dropped calls
    `ASSERT_CLKD(a_drop_only, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_DISMISSED |-> m_tdata[93:87] == 7'd0, "dropped count outside dismiss")

    // reset empties the result register
    `ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind three_class_priority_call_queue tcpq_checker u_tcpq_checker (.*);

`default_nettype wire
